FILE: sv/dqd_pkg.sv
// ----------------------------------------------------------------------------
// dqd_pkg - shared types and constants for the dual quadrature decoder
// Pin map struct, step direction, register indexes and field widths.
// ----------------------------------------------------------------------------
package dqd_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int PIN_W       = 6;
  localparam int REPORT_W    = 32;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 8;                 // pin_number + level, byte padded
  localparam int OUT_DATA_W  = 136;               // 4 x 32 + pin_matched, byte padded

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_A  = 2'd0,
    REG_LEFT_B  = 2'd1,
    REG_RIGHT_A = 2'd2,
    REG_RIGHT_B = 2'd3
  } cfg_reg_t;

  localparam logic [PIN_W-1:0] LEFT_A_PIN_RST  = 6'd0;
  localparam logic [PIN_W-1:0] LEFT_B_PIN_RST  = 6'd1;
  localparam logic [PIN_W-1:0] RIGHT_A_PIN_RST = 6'd2;
  localparam logic [PIN_W-1:0] RIGHT_B_PIN_RST = 6'd3;

  typedef struct packed {
    logic [PIN_W-1:0] left_a;
    logic [PIN_W-1:0] left_b;
    logic [PIN_W-1:0] right_a;
    logic [PIN_W-1:0] right_b;
  } pin_map_t;

  // one-hot-or-zero channel hit after priority matching
  typedef struct packed {
    logic left_a;
    logic left_b;
    logic right_a;
    logic right_b;
  } pin_hit_t;

  // per-wheel control for one item
  typedef struct packed {
    logic take;    // item moves into the result register this cycle
    logic sample;  // sample request
    logic hit_a;
    logic hit_b;
    logic level;
  } wheel_ctl_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  // x4 transition, state coded {A,B}; A leading B counts up
  function automatic step_t step_dir(input logic [1:0] old_s, input logic [1:0] new_s);
    step_t d;
    unique case ({old_s, new_s})
      4'b0010, 4'b0100, 4'b1011, 4'b1101: d = STEP_UP;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: d = STEP_DOWN;
      default:                            d = STEP_NONE;
    endcase
    return d;
  endfunction

endpackage

FILE: sv/dqd_match.sv
// ----------------------------------------------------------------------------
// dqd_match - pin number match
// Compares an edge pin against the four configured channel pins in fixed
// priority order (left A, left B, right A, right B).
// ----------------------------------------------------------------------------
module dqd_match (
  input  dqd_pkg::pin_map_t              pins,
  input  logic                           edge_ev,
  input  logic [dqd_pkg::PIN_W-1:0]      pin_number,
  output dqd_pkg::pin_hit_t              hit
);

  always_comb begin
    hit = '0;
    if (edge_ev) begin
      priority if (pin_number == pins.left_a) begin
        hit.left_a = 1'b1;
      end else if (pin_number == pins.left_b) begin
        hit.left_b = 1'b1;
      end else if (pin_number == pins.right_a) begin
        hit.right_a = 1'b1;
      end else if (pin_number == pins.right_b) begin
        hit.right_b = 1'b1;
      end else begin
        hit = '0;
      end
    end
  end

endmodule

FILE: sv/dqd_wheel.sv
// ----------------------------------------------------------------------------
// dqd_wheel - one wheel's x4 counter
// Holds the A/B levels, the wrapping tick count and the count saved at the
// last sample. Gives the count after this item and the delta for a sample.
// ----------------------------------------------------------------------------
module dqd_wheel #(
  parameter int COUNT_WIDTH = dqd_pkg::COUNT_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dqd_pkg::wheel_ctl_t     ctl,
  output logic [COUNT_WIDTH-1:0]  position,
  output logic [COUNT_WIDTH-1:0]  delta
);

  logic                   a_r, a_nxt;
  logic                   b_r, b_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [COUNT_WIDTH-1:0] saved_r;
  dqd_pkg::step_t         dir;

  always_comb begin
    a_nxt = ctl.hit_a ? ctl.level : a_r;
    b_nxt = ctl.hit_b ? ctl.level : b_r;
    dir   = dqd_pkg::step_dir({a_r, b_r}, {a_nxt, b_nxt});
    unique case (dir)
      dqd_pkg::STEP_UP:   count_nxt = count_r + COUNT_WIDTH'(1);
      dqd_pkg::STEP_DOWN: count_nxt = count_r - COUNT_WIDTH'(1);
      default:            count_nxt = count_r;
    endcase
  end

  assign position = count_nxt;
  assign delta    = ctl.sample ? (count_r - saved_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r     <= 1'b0;
      b_r     <= 1'b0;
      count_r <= '0;
      saved_r <= '0;
    end else if (ctl.take) begin
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      count_r <= count_nxt;
      if (ctl.sample) begin
        saved_r <= count_r;
      end
    end
  end

endmodule

FILE: sv/dual_quadrature_decoder_top.sv
// ----------------------------------------------------------------------------
// dual_quadrature_decoder_top - two-wheel x4 quadrature decoder
// Pin edge events step the left/right tick counters; sample requests report
// counts and deltas since the previous sample.
// ----------------------------------------------------------------------------
//  channel  direction  signals                               transfer when
//  in       slave      in_tvalid/in_tready/in_tdata/in_tuser  tvalid & tready
//  out      master     out_tvalid/out_tready/out_tdata        tvalid & tready
//  cfg      slave      cfg_valid/cfg_ready/cfg_index/cfg_data  valid & ready
//
//  One item per cycle sustained while out_tready stays high; an item passes
//  the input register, then match + counter step into the result register.
//  The result register holds while out_tready is low; the input register
//  still takes one item in that time, then in_tready drops.
//  rst_n is synchronous: clears pipeline valids, levels and counters, and
//  loads the default pin map 0,1,2,3. cfg_ready is always high.
// ----------------------------------------------------------------------------
module dual_quadrature_decoder_top #(
  parameter int COUNT_WIDTH = dqd_pkg::COUNT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [dqd_pkg::IN_DATA_W-1:0]     in_tdata,   // [5:0] pin_number, [6] level
  input  logic                              in_tuser,   // [0] cmd
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] left_position, [63:32] right_position, [95:64] left_delta,
  // [127:96] right_delta, [128] pin_matched
  output logic [dqd_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dqd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dqd_pkg::PIN_W-1:0]         cfg_data
);

  localparam int RW = dqd_pkg::REPORT_W;

  dqd_pkg::pin_map_t pins_r;

  logic                      s1_valid_r;
  logic                      s1_cmd_r;
  logic [dqd_pkg::PIN_W-1:0] s1_pin_r;
  logic                      s1_level_r;

  logic                      out_valid_r;
  logic [RW-1:0]             left_pos_r, right_pos_r, left_dlt_r, right_dlt_r;
  logic                      matched_r;

  logic                      out_free;
  logic                      take;
  dqd_pkg::pin_hit_t         hit;
  dqd_pkg::wheel_ctl_t       left_ctl, right_ctl;
  logic [COUNT_WIDTH-1:0]    left_pos, right_pos, left_dlt, right_dlt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pins_r.left_a  <= dqd_pkg::LEFT_A_PIN_RST;
      pins_r.left_b  <= dqd_pkg::LEFT_B_PIN_RST;
      pins_r.right_a <= dqd_pkg::RIGHT_A_PIN_RST;
      pins_r.right_b <= dqd_pkg::RIGHT_B_PIN_RST;
    end else if (cfg_valid) begin
      unique case (dqd_pkg::cfg_reg_t'(cfg_index))
        dqd_pkg::REG_LEFT_A:  pins_r.left_a  <= cfg_data;
        dqd_pkg::REG_LEFT_B:  pins_r.left_b  <= cfg_data;
        dqd_pkg::REG_RIGHT_A: pins_r.right_a <= cfg_data;
        dqd_pkg::REG_RIGHT_B: pins_r.right_b <= cfg_data;
      endcase
    end
  end

  // stage advance
  assign out_free  = !out_valid_r || out_tready;
  assign take      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r   <= in_tuser;
      s1_pin_r   <= in_tdata[dqd_pkg::PIN_W-1:0];
      s1_level_r <= in_tdata[dqd_pkg::PIN_W];
    end
  end

  dqd_match u_match (
    .pins       (pins_r),
    .edge_ev    (!s1_cmd_r),
    .pin_number (s1_pin_r),
    .hit        (hit)
  );

  always_comb begin
    left_ctl.take    = take;
    left_ctl.sample  = s1_cmd_r;
    left_ctl.hit_a   = hit.left_a;
    left_ctl.hit_b   = hit.left_b;
    left_ctl.level   = s1_level_r;
    right_ctl.take   = take;
    right_ctl.sample = s1_cmd_r;
    right_ctl.hit_a  = hit.right_a;
    right_ctl.hit_b  = hit.right_b;
    right_ctl.level  = s1_level_r;
  end

  dqd_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (left_ctl),
    .position (left_pos),
    .delta    (left_dlt)
  );

  dqd_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (right_ctl),
    .position (right_pos),
    .delta    (right_dlt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  // counts are sign-extended or truncated to the 32-bit report width
  always_ff @(posedge clk) begin
    if (take) begin
      left_pos_r  <= RW'($signed(left_pos));
      right_pos_r <= RW'($signed(right_pos));
      left_dlt_r  <= RW'($signed(left_dlt));
      right_dlt_r <= RW'($signed(right_dlt));
      matched_r   <= |hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, matched_r, right_dlt_r, left_dlt_r, right_pos_r, left_pos_r};

endmodule

FILE: sv/dqd_checker.sv
// ----------------------------------------------------------------------------
// dqd_checker - port-level checks for the dual quadrature decoder
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module dqd_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dqd_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // a matched edge never carries deltas
  a_match_no_delta: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[127:64] == '0)
    else $error("pin_matched with nonzero delta");

  // one accepted item yields one result through the input and result registers when nothing stalls
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tready ##1 out_tready |=> out_tvalid)
    else $error("accepted item produced no result");

endmodule

bind dual_quadrature_decoder_top dqd_checker u_dqd_checker (.*);

FILE: tb/sv/dual_quadrature_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_quadrature_decoder_top_tb - self-checking bench for the x4 decoder
// A short table of directed items and pin map loads is followed by random
// phases, each with its own pin map. Most random edges walk a wheel through
// legal quadrature sequences; the rest are stray pins, repeated levels and
// sample requests. Every accepted item is run through a local decoder model
// and its report is compared with the next transfer on the result stream.
// ----------------------------------------------------------------------------
module dual_quadrature_decoder_top_tb;

  localparam logic CMD_EDGE   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;
  localparam int   GAP_PCT    = 27;
  localparam int   PHASES     = 8;
  localparam int   PHASE_ITEMS = 250;
  localparam int   RW         = dqd_pkg::REPORT_W;
  localparam int   PW         = dqd_pkg::PIN_W;
  localparam int   CW         = dqd_pkg::COUNT_WIDTH;

  typedef enum logic { ROW_ITEM, ROW_CFG } row_kind_t;

  typedef struct packed {
    logic [RW-1:0] left_pos;
    logic [RW-1:0] right_pos;
    logic [RW-1:0] left_delta;
    logic [RW-1:0] right_delta;
    logic          matched;
  } wheel_report_t;

  typedef struct packed {
    row_kind_t          kind;
    logic               cmd;
    logic [PW-1:0]      pin;
    logic               level;
    dqd_pkg::pin_map_t  map;
    logic               typed;
    wheel_report_t      report;
  } stim_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [dqd_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [dqd_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dqd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [PW-1:0]                  cfg_data;

  // decoder model state
  dqd_pkg::pin_map_t pins;
  logic              lv_la, lv_lb, lv_ra, lv_rb;
  logic [CW-1:0]     cnt_l, cnt_r, snap_l, snap_r;

  wheel_report_t pending_reports[$];
  stim_row_t     dir_rows[$];
  int            fail_cnt  = 0;
  int            hold_cnt  = 0;
  bit            hold_go   = 1'b0;
  bit            hold_done = 1'b0;
  bit            calm      = 1'b0;

  dual_quadrature_decoder_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [5:0] pin_number, [6] level, [7] zero
    .in_tuser   (in_tuser),    // [0] cmd
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // [31:0] left_position, [63:32] right_position, [95:64] left_delta,
    // [127:96] right_delta, [128] pin_matched
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #2_000_000;
    $display("dual_quadrature_decoder_top_tb: FAIL");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [RW-1:0] to_report(input logic [CW-1:0] v);
    return RW'(signed'(v));
  endfunction

  // position along the up sequence 00 -> 10 -> 11 -> 01, state is {A,B}
  function automatic logic [1:0] gray_pos(input logic [1:0] s);
    return {s[0], s[1] ^ s[0]};
  endfunction

  function automatic logic [CW-1:0] quad_count(input logic [CW-1:0] c,
                                               input logic [1:0] old_s,
                                               input logic [1:0] new_s);
    logic [1:0]     span;
    dqd_pkg::step_t dir;
    span = gray_pos(new_s) - gray_pos(old_s);
    dir  = (span == 2'd1) ? dqd_pkg::STEP_UP :
           (span == 2'd3) ? dqd_pkg::STEP_DOWN : dqd_pkg::STEP_NONE;
    unique case (dir)
      dqd_pkg::STEP_UP:   return c + CW'(1);
      dqd_pkg::STEP_DOWN: return c - CW'(1);
      default:            return c;
    endcase
  endfunction

  task automatic decode_event(input logic c, input logic [PW-1:0] p, input logic l,
                              output wheel_report_t r);
    r = '0;
    if (c == CMD_EDGE) begin
      r.matched = 1'b1;
      if (p == pins.left_a) begin
        cnt_l = quad_count(cnt_l, {lv_la, lv_lb}, {l, lv_lb});
        lv_la = l;
      end else if (p == pins.left_b) begin
        cnt_l = quad_count(cnt_l, {lv_la, lv_lb}, {lv_la, l});
        lv_lb = l;
      end else if (p == pins.right_a) begin
        cnt_r = quad_count(cnt_r, {lv_ra, lv_rb}, {l, lv_rb});
        lv_ra = l;
      end else if (p == pins.right_b) begin
        cnt_r = quad_count(cnt_r, {lv_ra, lv_rb}, {lv_ra, l});
        lv_rb = l;
      end else begin
        r.matched = 1'b0;
      end
    end else begin
      r.left_delta  = to_report(cnt_l - snap_l);
      r.right_delta = to_report(cnt_r - snap_r);
      snap_l = cnt_l;
      snap_r = cnt_r;
    end
    r.left_pos  = to_report(cnt_l);
    r.right_pos = to_report(cnt_r);
  endtask

  // ---------------------------------------------------------------- drivers

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic c, input logic [PW-1:0] p, input logic l,
                           input logic typed, input wheel_report_t typed_rpt);
    wheel_report_t r;
    while (!calm && $urandom_range(0, 99) < GAP_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= c;
    in_tdata  <= {1'b0, l, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_event(c, p, l, r);
    pending_reports.push_back(typed ? typed_rpt : r);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic load_pin_map(input dqd_pkg::pin_map_t m);
    logic [PW-1:0]     vals[4];
    dqd_pkg::cfg_reg_t idx;
    vals = '{m.left_a, m.left_b, m.right_a, m.right_b};
    for (int i = 0; i < 4; i++) begin
      idx = dqd_pkg::cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        dqd_pkg::REG_LEFT_A:  pins.left_a  = vals[i];
        dqd_pkg::REG_LEFT_B:  pins.left_b  = vals[i];
        dqd_pkg::REG_RIGHT_A: pins.right_a = vals[i];
        dqd_pkg::REG_RIGHT_B: pins.right_b = vals[i];
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt   <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_go && !hold_done) begin
      hold_cnt   <= 400;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  task automatic check_field(input string name, input logic [RW-1:0] exp_v,
                             input logic [RW-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(got_v));
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    wheel_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with no item outstanding");
        fail_cnt++;
      end else begin
        want = pending_reports.pop_front();
        check_field("left_position",  want.left_pos,    out_tdata[31:0]);
        check_field("right_position", want.right_pos,   out_tdata[63:32]);
        check_field("left_delta",     want.left_delta,  out_tdata[95:64]);
        check_field("right_delta",    want.right_delta, out_tdata[127:96]);
        check_field("pin_matched",    RW'(want.matched), RW'(out_tdata[128]));
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic stim_row_t ev(input logic c, input logic [PW-1:0] p,
                                   input logic l);
    stim_row_t row;
    row       = '0;
    row.kind  = ROW_ITEM;
    row.cmd   = c;
    row.pin   = p;
    row.level = l;
    return row;
  endfunction

  function automatic stim_row_t evx(input logic c, input logic [PW-1:0] p,
                                    input logic l, input int lp, input int rp,
                                    input int ld, input int rd, input logic m);
    stim_row_t row;
    row        = ev(c, p, l);
    row.typed  = 1'b1;
    row.report = '{left_pos: lp, right_pos: rp, left_delta: ld, right_delta: rd,
                   matched: m};
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [PW-1:0] la,
                                        input logic [PW-1:0] lb,
                                        input logic [PW-1:0] ra,
                                        input logic [PW-1:0] rb);
    stim_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.map  = '{left_a: la, left_b: lb, right_a: ra, right_b: rb};
    return row;
  endfunction

  initial begin
    stim_row_t         row;
    dqd_pkg::pin_map_t m;
    logic              wheel_dir[2];
    logic              wheel, up, a_lv, b_lv, use_a, l;
    logic [PW-1:0]     p;
    int                roll, n;

    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_EDGE;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= dqd_pkg::REG_LEFT_A;
    cfg_data   <= '0;

    pins  = '{left_a: dqd_pkg::LEFT_A_PIN_RST, left_b: dqd_pkg::LEFT_B_PIN_RST,
              right_a: dqd_pkg::RIGHT_A_PIN_RST, right_b: dqd_pkg::RIGHT_B_PIN_RST};
    {lv_la, lv_lb, lv_ra, lv_rb} = '0;
    {cnt_l, cnt_r, snap_l, snap_r} = '0;

    // default map 0,1,2,3 until the first load
    dir_rows.push_back(evx(CMD_SAMPLE, 6'd0,  1'b0, 0, 0, 0, 0, 1'b0));
    dir_rows.push_back(evx(CMD_EDGE,   6'd0,  1'b1, 1, 0, 0, 0, 1'b1));
    dir_rows.push_back(evx(CMD_EDGE,   6'd1,  1'b1, 2, 0, 0, 0, 1'b1));
    dir_rows.push_back(evx(CMD_EDGE,   6'd0,  1'b0, 3, 0, 0, 0, 1'b1));
    dir_rows.push_back(evx(CMD_EDGE,   6'd1,  1'b0, 4, 0, 0, 0, 1'b1));
    dir_rows.push_back(evx(CMD_SAMPLE, 6'd63, 1'b1, 4, 0, 4, 0, 1'b0));
    dir_rows.push_back(evx(CMD_EDGE,   6'd1,  1'b1, 3, 0, 0, 0, 1'b1)); // B leads: down
    dir_rows.push_back(evx(CMD_EDGE,   6'd1,  1'b1, 3, 0, 0, 0, 1'b1)); // level repeated
    dir_rows.push_back(ev(CMD_EDGE,   6'd2,  1'b1));
    dir_rows.push_back(ev(CMD_EDGE,   6'd3,  1'b1));
    dir_rows.push_back(ev(CMD_EDGE,   6'd2,  1'b0));
    dir_rows.push_back(evx(CMD_EDGE,   6'd63, 1'b1, 3, 3, 0, 0, 1'b0)); // stray pin
    dir_rows.push_back(ev(CMD_SAMPLE, 6'd0,  1'b0));
    dir_rows.push_back(ev(CMD_SAMPLE, 6'd42, 1'b1));
    // overlapping pins: priority order decides
    dir_rows.push_back(cfg_row(6'd63, 6'd63, 6'd0, 6'd0));
    dir_rows.push_back(ev(CMD_EDGE,   6'd63, 1'b1));
    dir_rows.push_back(ev(CMD_EDGE,   6'd0,  1'b1));
    dir_rows.push_back(ev(CMD_EDGE,   6'd63, 1'b0));
    dir_rows.push_back(cfg_row(6'd10, 6'd20, 6'd30, 6'd40));
    dir_rows.push_back(ev(CMD_EDGE,   6'd20, 1'b0));
    dir_rows.push_back(ev(CMD_EDGE,   6'd40, 1'b0));
    dir_rows.push_back(ev(CMD_EDGE,   6'd3,  1'b1));
    dir_rows.push_back(ev(CMD_SAMPLE, 6'd0,  1'b0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        load_pin_map(row.map);
      end else begin
        send_item(row.cmd, row.pin, row.level, row.typed, row.report);
      end
    end

    n = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: m = '{left_a: 6'd63, left_b: 6'd0, right_a: 6'd62, right_b: 6'd1};
        1: m = '{left_a: 6'd63, left_b: 6'd63, right_a: 6'd63, right_b: 6'd63};
        2: m = '{left_a: 6'd0, left_b: 6'd0, right_a: 6'd0, right_b: 6'd0};
        3: m = '{left_a: dqd_pkg::LEFT_A_PIN_RST, left_b: dqd_pkg::LEFT_B_PIN_RST,
                 right_a: dqd_pkg::RIGHT_A_PIN_RST, right_b: dqd_pkg::RIGHT_B_PIN_RST};
        default: m = '{left_a: PW'($urandom_range(0, 63)),
                       left_b: PW'($urandom_range(0, 63)),
                       right_a: PW'($urandom_range(0, 63)),
                       right_b: PW'($urandom_range(0, 63))};
      endcase
      drain();
      load_pin_map(m);
      wheel_dir[0] = 1'($urandom_range(0, 1));
      wheel_dir[1] = 1'($urandom_range(0, 1));

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n++;
        if (n == 300) hold_go = 1'b1;
        calm = (n >= 1000 && n < 1400);
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          send_item(CMD_SAMPLE, PW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                    1'b0, '0);
        end else if (roll < 80) begin
          // step one wheel along its current direction, now and then against it
          wheel = 1'($urandom_range(0, 1));
          up    = wheel_dir[wheel] ^ ($urandom_range(0, 4) == 0);
          a_lv  = wheel ? lv_ra : lv_la;
          b_lv  = wheel ? lv_rb : lv_lb;
          use_a = ((a_lv == b_lv) == up);
          if (wheel) p = use_a ? pins.right_a : pins.right_b;
          else       p = use_a ? pins.left_a  : pins.left_b;
          l = use_a ? !a_lv : !b_lv;
          send_item(CMD_EDGE, p, l, 1'b0, '0);
        end else begin
          send_item(CMD_EDGE, PW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                    1'b0, '0);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (fail_cnt == 0 && pending_reports.size() == 0) begin
      $display("dual_quadrature_decoder_top_tb: PASS");
    end else begin
      $display("dual_quadrature_decoder_top_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/dqd_pkg.sv
sv/dqd_match.sv
sv/dqd_wheel.sv
sv/dual_quadrature_decoder_top.sv
sv/dqd_checker.sv
tb/sv/dual_quadrature_decoder_top_tb.sv
